// File: hw/rtl/cubtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_pkg
// Shared types and constants of the cubic true-peak tracker.
// ----------------------------------------------------------------------------
package cubtp_pkg;

	typedef logic [2:0]         chan_t;
	typedef logic signed [23:0] sample_t;
	typedef logic [31:0]        peak_t;
	typedef logic [1:0]         fill_t;

	// Cubic coefficients A, B, C in 2^-23 units
	typedef logic signed [27:0] coef_t;
	// Interpolated value in 2^-30 units
	typedef logic signed [35:0] interp_t;

	localparam fill_t FILL_FULL = 2'd3;

	typedef struct packed {
		fill_t   fill;
		sample_t h2;
		sample_t h1;
		sample_t h0;
	} hist_entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/cubtp_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_sample_if
// Sample channel: channel index, sample word and not-finite flag.
// ----------------------------------------------------------------------------
interface cubtp_sample_if;
	logic               valid;
	logic               ready;
	cubtp_pkg::chan_t   chan;
	cubtp_pkg::sample_t sample;
	logic               not_finite;

	modport source (output valid, output chan, output sample, output not_finite,
		input ready);
	modport sink (input valid, input chan, input sample, input not_finite,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cubtp_peak_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_peak_if
// Peak channel: running true-peak magnitude word.
// ----------------------------------------------------------------------------
interface cubtp_peak_if;
	logic             valid;
	logic             ready;
	cubtp_pkg::peak_t peak;

	modport source (output valid, output peak, input ready);
	modport sink (input valid, input peak, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cubtp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cubtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/cubtp_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_interp
// Catmull-Rom cubic at t = 1/4, 1/2, 3/4 by shift-add, in 2^-30 units.
// ----------------------------------------------------------------------------
module cubtp_interp (
	input  wire cubtp_pkg::coef_t   a,
	input  wire cubtp_pkg::coef_t   b,
	input  wire cubtp_pkg::coef_t   c,
	input  wire cubtp_pkg::sample_t p1,
	output cubtp_pkg::interp_t      v1,
	output cubtp_pkg::interp_t      v2,
	output cubtp_pkg::interp_t      v3
);
	import cubtp_pkg::*;

	interp_t ae, be, ce, base;

	assign ae   = interp_t'(a);
	assign be   = interp_t'(b);
	assign ce   = interp_t'(c);
	assign base = interp_t'(p1) <<< 7;

	assign v1 = ae + (be <<< 2) + (ce <<< 4) + base;
	assign v2 = (ae <<< 3) + (be <<< 4) + (ce <<< 5) + base;
	assign v3 = (ae <<< 4) + (ae <<< 3) + (ae <<< 1) + ae
		+ (be <<< 5) + (be <<< 2)
		+ (ce <<< 5) + (ce <<< 4) + base;

endmodule
`default_nettype wire

// File: hw/rtl/cubic_true_peak_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_true_peak_tracker
// Running true-peak meter over interleaved audio with 4x cubic interpolation.
// ----------------------------------------------------------------------------
// Takes one sample word per cycle unless the output stalls and returns one
// peak word per sample. Each channel's last three samples and fill count live
// in one RAM entry, read when the sample is taken and written back as it
// leaves stage 1; a sample for that channel taken during the write gets the
// new entry by forwarding. Entries read as zero until first written. The peak
// is the largest magnitude, in 2^-30 units and saturating at all ones, over
// raw samples and over the cubic between the middle two of a channel's last
// four samples at t = 1/4, 1/2 and 3/4. A channel index at or above CHANNELS
// leaves all state alone and reports the current peak. A not-finite sample
// counts and is stored as zero.
// ----------------------------------------------------------------------------
module cubic_true_peak_tracker #(
	parameter int CHANNELS = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	cubtp_sample_if.sink   samples,
	cubtp_peak_if.source   peaks
);
	import cubtp_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	function automatic peak_t sat_mag(input interp_t v);
		interp_t m;
		m = v[$bits(interp_t)-1] ? -v : v;
		if (|m[$bits(interp_t)-1:32]) begin
			return '1;
		end
		return m[31:0];
	endfunction

	function automatic peak_t max2(input peak_t x, input peak_t y);
		return (x > y) ? x : y;
	endfunction

	// Stage enables
	logic s1_v, s2_v, s3_v, s4_v, out_v_q;
	logic s1_en, s2_en, s3_en, s4_en, out_en;
	logic acc;

	assign out_en = !out_v_q || peaks.ready;
	assign s4_en  = !s4_v || out_en;
	assign s3_en  = !s3_v || s4_en;
	assign s2_en  = !s2_v || s3_en;
	assign s1_en  = !s1_v || s2_en;
	assign samples.ready = s1_en;
	assign acc    = samples.valid && s1_en;

	// Input decode
	logic [AW-1:0] addr_in;
	logic          range_in;
	sample_t       smp_in;

	assign addr_in  = AW'(samples.chan);
	assign range_in = ({29'd0, samples.chan} < 32'(CHANNELS));
	assign smp_in   = samples.not_finite ? '0 : samples.sample;

	// History RAM and entry valid bits
	logic [CHANNELS-1:0] valid_q;
	hist_entry_t         ram_rdata, entry_s1, new_entry;
	logic                wr_en;
	logic [AW-1:0]       addr_s1;
	logic                range_s1, vld_s1, fwd_s1;
	sample_t             p3_s1;
	hist_entry_t         fwd_data_s1;

	assign wr_en = s1_v && s2_en && range_s1;

	cubtp_ram #(
		.WIDTH($bits(hist_entry_t)),
		.DEPTH(CHANNELS)
	) u_hist_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (new_entry),
		.re    (acc),
		.raddr (addr_in),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	// Stage 1: entry read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_en) begin
			s1_v <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1     <= addr_in;
			range_s1    <= range_in;
			p3_s1       <= smp_in;
			vld_s1      <= range_in && valid_q[addr_in];
			fwd_s1      <= wr_en && (addr_in == addr_s1);
			fwd_data_s1 <= new_entry;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			entry_s1 = fwd_data_s1;
		end else if (vld_s1) begin
			entry_s1 = ram_rdata;
		end else begin
			entry_s1 = '0;
		end
		new_entry.fill = (entry_s1.fill == FILL_FULL) ? FILL_FULL : entry_s1.fill + 2'd1;
		new_entry.h0   = entry_s1.h1;
		new_entry.h1   = entry_s1.h2;
		new_entry.h2   = p3_s1;
	end

	// Coefficients and raw magnitude
	coef_t p0e, p1e, p2e, p3e, a_c, b_c, c_c;
	logic [23:0] abs_s1;

	assign p0e = coef_t'(entry_s1.h0);
	assign p1e = coef_t'(entry_s1.h1);
	assign p2e = coef_t'(entry_s1.h2);
	assign p3e = coef_t'(p3_s1);
	assign a_c = -p0e + (p1e <<< 1) + p1e - (p2e <<< 1) - p2e + p3e;
	assign b_c = (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
	assign c_c = p2e - p0e;
	assign abs_s1 = p3_s1[23] ? 24'(-p3_s1) : 24'(p3_s1);

	coef_t   a_s2, b_s2, c_s2;
	sample_t p1_s2;
	peak_t   raw_s2;
	logic    interp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_en) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v && s2_en) begin
			a_s2      <= a_c;
			b_s2      <= b_c;
			c_s2      <= c_c;
			p1_s2     <= entry_s1.h1;
			raw_s2    <= range_s1 ? {1'b0, abs_s1, 7'd0} : '0;
			interp_s2 <= range_s1 && (entry_s1.fill == FILL_FULL);
		end
	end

	// Stage 2: cubic evaluation
	interp_t v1_c, v2_c, v3_c;

	cubtp_interp u_interp (
		.a  (a_s2),
		.b  (b_s2),
		.c  (c_s2),
		.p1 (p1_s2),
		.v1 (v1_c),
		.v2 (v2_c),
		.v3 (v3_c)
	);

	interp_t v1_s3, v2_s3, v3_s3;
	peak_t   raw_s3;
	logic    interp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (s3_en) begin
			s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && s3_en) begin
			v1_s3     <= v1_c;
			v2_s3     <= v2_c;
			v3_s3     <= v3_c;
			raw_s3    <= raw_s2;
			interp_s3 <= interp_s2;
		end
	end

	// Stage 3: saturate and pair maxima
	peak_t m1_c, m2_c, m3_c;
	peak_t pa_s4, pb_s4;

	assign m1_c = interp_s3 ? sat_mag(v1_s3) : '0;
	assign m2_c = interp_s3 ? sat_mag(v2_s3) : '0;
	assign m3_c = interp_s3 ? sat_mag(v3_s3) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_v <= 1'b0;
		end else if (s4_en) begin
			s4_v <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_v && s4_en) begin
			pa_s4 <= max2(raw_s3, m1_c);
			pb_s4 <= max2(m2_c, m3_c);
		end
	end

	// Stage 4: fold into the running peak
	peak_t peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			peak_q  <= '0;
		end else if (out_en) begin
			out_v_q <= s4_v;
			if (s4_v) begin
				peak_q <= max2(peak_q, max2(pa_s4, pb_s4));
			end
		end
	end

	assign peaks.valid = out_v_q;
	assign peaks.peak  = peak_q;

endmodule
`default_nettype wire

// File: hw/rtl/cubtp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubtp_checker
// Port-level checks of the cubic true-peak tracker, bound to the top level.
// ----------------------------------------------------------------------------
module cubtp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire cubtp_pkg::peak_t out_peak
);
	import cubtp_pkg::*;

	localparam logic [3:0] PIPE_CAP = 4'd5;

	logic       in_acc, out_acc;
	logic [3:0] occ_q;
	peak_t      last_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			last_q <= '0;
		end else begin
			occ_q <= occ_q + 4'(in_acc) - 4'(out_acc);
			if (out_acc) begin
				last_q <= out_peak;
			end
		end
	end

	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> out_peak >= last_q)
		else $error("peak word decreased");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> occ_q != 4'd0)
		else $error("peak word without a sample word");

	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= PIPE_CAP)
		else $error("more words in flight than stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == 4'd0 |-> in_ready)
		else $error("empty pipeline refuses a sample word");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_peak))
		else $error("stalled peak word changed");

endmodule

bind cubic_true_peak_tracker cubtp_checker u_cubtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (peaks.valid),
	.out_ready (peaks.ready),
	.out_peak  (peaks.peak)
);
`default_nettype wire

// File: tb/tb_cubic_true_peak_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_cubic_true_peak_tracker
// Self-checking bench for the cubic true-peak tracker.
// ----------------------------------------------------------------------------
// Drives interleaved sample words through the sample channel. A scoreboard
// class predicts the running peak for every accepted word, from the raw
// magnitude and the 4x cubic interpolation. It compares each peak word
// against the oldest prediction. Directed cases open the run: not-finite
// words, warm-up of a channel, back-to-back words on one channel, overshoot
// between samples and a not-finite word in a history. Random words follow,
// with an amplitude that grows over the run so the peak keeps moving. The
// random part is mostly smooth per-channel walks, with scattered noise and
// not-finite words. A closing burst drives the full-scale extremes. Phases
// vary source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_cubic_true_peak_tracker;
	import cubtp_pkg::*;

	localparam int CHANNELS       = 8;
	localparam int RANDOM_WORDS   = 450;
	localparam int NUM_PHASES     = 4;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;

	localparam sample_t FULL_POS = 24'sh7FFFFF;
	localparam sample_t FULL_NEG = 24'sh800000;

	class peak_scoreboard;
		sample_t hist[CHANNELS][3];
		fill_t   fill[CHANNELS];
		peak_t   peak_hold;
		peak_t   expected_peaks[$];
		int      errors;

		function new();
			foreach (hist[i, j]) hist[i][j] = '0;
			foreach (fill[i]) fill[i] = '0;
			peak_hold = '0;
			errors = 0;
		endfunction

		function void fold_magnitude(longint v);
			longint m;
			m = (v < 0) ? -v : v;
			if (m > 64'sh0_FFFF_FFFF)
				m = 64'sh0_FFFF_FFFF;
			if (m > longint'(peak_hold))
				peak_hold = peak_t'(m);
		endfunction

		function void note_sample(chan_t ch, sample_t smp, logic nf);
			sample_t s;
			longint  p0, p1, p2, p3, a, b, c, k;
			s = nf ? sample_t'(0) : smp;
			if (int'(ch) < CHANNELS) begin
				p0 = hist[ch][0];
				p1 = hist[ch][1];
				p2 = hist[ch][2];
				p3 = s;
				hist[ch][0] = hist[ch][1];
				hist[ch][1] = hist[ch][2];
				hist[ch][2] = s;
				fold_magnitude(p3 * 128);
				if (fill[ch] == FILL_FULL) begin
					a = -p0 + 3 * p1 - 3 * p2 + p3;
					b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
					c = p2 - p0;
					for (k = 1; k <= 3; k++)
						fold_magnitude(a * k * k * k + 4 * b * k * k + 16 * c * k + 128 * p1);
				end else begin
					fill[ch] = fill[ch] + fill_t'(1);
				end
			end
			expected_peaks = {expected_peaks, peak_hold};
		endfunction

		function void check_peak(peak_t got);
			peak_t want;
			if (expected_peaks.size() == 0) begin
				$display("%0t: peak word with none expected: expected none, actual %h",
					$time, got);
				errors++;
			end else begin
				want = expected_peaks.pop_front();
				if (got !== want) begin
					$display("%0t: peak mismatch: expected %h, actual %h", $time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cubtp_sample_if samples();
	cubtp_peak_if   peaks();

	cubic_true_peak_tracker #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.peaks  (peaks)
	);

	peak_scoreboard sb;
	int             idle_pct;
	int             stall_pct;
	int             walk[CHANNELS];
	chan_t          last_chan;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic push_sample(chan_t ch, sample_t smp, logic nf);
		while ($urandom_range(0, 99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid      <= 1'b1;
		samples.chan       <= ch;
		samples.sample     <= smp;
		samples.not_finite <= nf;
		do
			@(posedge clk);
		while (!(samples.valid && samples.ready));
		sb.note_sample(ch, smp, nf);
		last_chan = ch;
	endtask

	task automatic push_random(int idx);
		int    amp_bits;
		int    amp;
		int    kind;
		int    step;
		int    value;
		chan_t ch;
		amp_bits = 2 + (idx * 21) / RANDOM_WORDS;
		amp = (1 << amp_bits) + int'($urandom_range(0, (1 << amp_bits) - 1));
		if ($urandom_range(0, 9) < 4)
			ch = last_chan;
		else
			ch = chan_t'($urandom_range(0, 7));
		kind = $urandom_range(0, 19);
		if (kind < 13) begin
			step = int'($urandom_range(0, amp / 2)) - amp / 4;
			value = walk[ch] + step;
			if (value > amp)
				value = amp;
			if (value < -amp)
				value = -amp;
			walk[ch] = value;
			push_sample(ch, sample_t'(value), 1'b0);
		end else if (kind < 19) begin
			value = int'($urandom_range(0, 2 * amp)) - amp;
			push_sample(ch, sample_t'(value), 1'b0);
		end else begin
			push_sample(ch, sample_t'($urandom_range(0, 24'hFFFFFF)), 1'b1);
		end
	endtask

	always @(posedge clk) begin
		peaks.ready <= ($urandom_range(0, 99) >= stall_pct);
		if (arst_n && peaks.valid && peaks.ready)
			sb.check_peak(peaks.peak);
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((samples.valid && samples.ready) || (peaks.valid && peaks.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int idle_table[NUM_PHASES];
		int stall_table[NUM_PHASES];
		int idx;
		idle_table  = '{0, 52, 0, 12};
		stall_table = '{0, 0, 52, 12};
		sb = new();
		foreach (walk[i]) walk[i] = 0;
		last_chan = '0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n             <= 1'b0;
		samples.valid      <= 1'b0;
		samples.chan       <= '0;
		samples.sample     <= '0;
		samples.not_finite <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not-finite words count as zero
		push_sample(3'd0, FULL_POS, 1'b1);
		push_sample(3'd1, FULL_NEG, 1'b1);
		push_sample(3'd2, -24'sd5, 1'b0);
		push_sample(3'd2, 24'sd1, 1'b0);
		push_sample(3'd2, -24'sd1, 1'b0);
		// warm-up, back-to-back on one channel
		push_sample(3'd3, 24'sd0, 1'b0);
		push_sample(3'd3, 24'sd0, 1'b0);
		push_sample(3'd3, 24'sd100, 1'b0);
		push_sample(3'd3, 24'sd0, 1'b0);
		// overshoot between two equal samples
		push_sample(3'd4, -24'sd120, 1'b0);
		push_sample(3'd4, 24'sd120, 1'b0);
		push_sample(3'd4, 24'sd120, 1'b0);
		push_sample(3'd4, -24'sd120, 1'b0);
		// not-finite word inside the history
		push_sample(3'd5, 24'sd300, 1'b0);
		push_sample(3'd5, -24'sd1, 1'b1);
		push_sample(3'd5, 24'sd300, 1'b0);
		push_sample(3'd5, 24'sd310, 1'b0);

		idx = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct = idle_table[ph];
			stall_pct = stall_table[ph];
			for (int n = 0; n < RANDOM_WORDS / NUM_PHASES + 1 && idx < RANDOM_WORDS; n++) begin
				push_random(idx);
				idx++;
			end
		end

		// full-scale extremes
		push_sample(3'd6, FULL_NEG, 1'b0);
		push_sample(3'd6, FULL_POS, 1'b0);
		push_sample(3'd6, FULL_POS, 1'b0);
		push_sample(3'd6, FULL_NEG, 1'b0);
		push_sample(3'd7, FULL_POS, 1'b0);
		push_sample(3'd7, FULL_NEG, 1'b0);
		push_sample(3'd7, FULL_NEG, 1'b0);
		push_sample(3'd7, FULL_POS, 1'b0);
		push_sample(3'd5, FULL_POS, 1'b0);

		samples.valid <= 1'b0;
		stall_pct = 0;
		while (sb.expected_peaks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/cubtp_pkg.sv
hw/rtl/cubtp_sample_if.sv
hw/rtl/cubtp_peak_if.sv
hw/rtl/cubtp_ram.sv
hw/rtl/cubtp_interp.sv
hw/rtl/cubic_true_peak_tracker.sv
hw/rtl/cubtp_checker.sv
tb/tb_cubic_true_peak_tracker.sv
